>>> rtl/core/rsi_pkg.sv
// Shared widths, types and register codes of the ray and sphere intersection unit.
package rsi_pkg;

    localparam int CoordW    = 32;                // Q16.16 coordinates
    localparam int DirW      = 16;                // Q2.14 directions and normals
    localparam int DistW     = 31;                // unsigned Q15.16 distance and radius
    localparam int DeltaW    = CoordW + 1;        // difference of two coordinates
    localparam int HW        = 51;                // dir . d in Q.30
    localparam int QW        = 100;               // discriminant quarter in Q.60
    localparam int RootW     = QW / 2;            // its square root in Q.30
    localparam int EeW       = 66;                // e . e in Q.32
    localparam int LenW      = EeW / 2;           // length of e in Q17.16
    localparam int QuoW      = 16;                // quotient bits of a normal component
    localparam int NumW      = LenW + QuoW - 1;   // numerator of a normal component
    localparam int FracBits  = 14;                // Q.30 to Q.16 and Q.14 scaling
    localparam int RoundHalf = 1 << (FracBits - 1);

    localparam logic [DirW-1:0] NormPosMax = {1'b0, {(DirW - 1){1'b1}}};
    localparam logic [DirW-1:0] NormMagMax = {1'b1, {(DirW - 1){1'b0}}};

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [DirW-1:0]   dir_t;
    typedef logic [DistW-1:0]         dist_t;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        coord_t [2:0] o;
        dir_t   [2:0] dv;
    } ray_t;

    // Carried alongside the first square root.
    typedef struct packed {
        logic                 miss;
        logic signed [HW-1:0] h;
        ray_t                 ray;
    } root_side_t;

    // Carried alongside the normal division.
    typedef struct packed {
        logic         miss;
        dist_t        t16;
        coord_t [2:0] p;
    } hit_side_t;

    // Carried alongside the second square root.
    typedef struct packed {
        hit_side_t              hs;
        logic [2:0][DeltaW-1:0] emag;
        logic [2:0]             esign;
    } norm_side_t;

endpackage

>>> rtl/core/ray_sphere_intersect_unit.sv
// Top level of the ray and sphere intersection unit.
// One ray beat is taken per cycle. The pipeline is made of the two bit-per-stage square
// roots (50 and 33 stages) and the 18-stage normal division, plus 7 + 7 front and middle
// stages and one output register.
// Reset clears the sphere registers to zero and empties the pipeline; busy is always low.
// The receiver cannot stall, so every result beat is shown for exactly one cycle.
module ray_sphere_intersect_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [31:0]        origin_x,
    input  logic signed [31:0]        origin_y,
    input  logic signed [31:0]        origin_z,
    input  logic signed [15:0]        dir_x,
    input  logic signed [15:0]        dir_y,
    input  logic signed [15:0]        dir_z,
    input  logic                      wr_en,
    input  logic [1:0]                wr_index,
    input  logic [31:0]               wr_data,
    output logic                      done,
    output logic                      hit,
    output logic [30:0]               hit_distance,
    output logic signed [31:0]        hit_x,
    output logic signed [31:0]        hit_y,
    output logic signed [31:0]        hit_z,
    output logic signed [15:0]        normal_x,
    output logic signed [15:0]        normal_y,
    output logic signed [15:0]        normal_z
);

    // Sphere registers. The user must see that they are written only while no ray is in
    // flight, so every stage may read them directly; the block does not enforce it.
    rsi_pkg::coord_t              cx_reg, cy_reg, cz_reg;
    rsi_pkg::dist_t               radius_reg;
    rsi_pkg::coord_t [2:0]        center;

    // Inter-module signals.
    rsi_pkg::ray_t                in_ray;
    logic                         quad_valid;
    logic [rsi_pkg::QW-1:0]       quad_q;
    rsi_pkg::root_side_t          quad_side;
    logic                         root_valid;
    logic [rsi_pkg::RootW-1:0]    root_s;
    rsi_pkg::root_side_t          root_side;
    logic                         pt_valid;
    logic [rsi_pkg::EeW-1:0]      pt_ee;
    rsi_pkg::norm_side_t          pt_side;
    logic                         len_valid;
    logic [rsi_pkg::LenW-1:0]     len_s;
    rsi_pkg::norm_side_t          len_side;
    logic                         div_valid;
    rsi_pkg::dir_t [2:0]          div_normal;
    rsi_pkg::hit_side_t           div_side;

    // Output register.
    logic                         done_reg;
    logic                         hit_reg;
    rsi_pkg::dist_t               dist_reg;
    rsi_pkg::coord_t [2:0]        point_reg;
    rsi_pkg::dir_t [2:0]          normal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= '0;
        end
        else if (wr_en)
        begin
            case (rsi_pkg::cfg_reg_t'(wr_index))
                rsi_pkg::REG_CENTER_X: cx_reg     <= wr_data;
                rsi_pkg::REG_CENTER_Y: cy_reg     <= wr_data;
                rsi_pkg::REG_CENTER_Z: cz_reg     <= wr_data;
                rsi_pkg::REG_RADIUS:   radius_reg <= wr_data[rsi_pkg::DistW-1:0];
                default:               radius_reg <= radius_reg;
            endcase
        end
    end

    assign center = {cz_reg, cy_reg, cx_reg};

    // The pipeline never stalls, so a start beat is always taken.
    assign busy      = 1'b0;
    assign in_ray.o  = {origin_z, origin_y, origin_x};
    assign in_ray.dv = {dir_z, dir_y, dir_x};

    // Offset, dot products and the quarter discriminant; a negative one marks a miss.
    rsi_quad u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .in_ray    (in_ray),
        .center    (center),
        .radius    (radius_reg),
        .out_valid (quad_valid),
        .out_q     (quad_q),
        .out_side  (quad_side)
    );

    // Square root of the discriminant in Q.30.
    rsi_isqrt #(
        .RAD_W  (rsi_pkg::QW),
        .SIDE_W ($bits(rsi_pkg::root_side_t))
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (quad_valid),
        .in_rad    (quad_q),
        .in_side   (quad_side),
        .out_valid (root_valid),
        .out_root  (root_s),
        .out_side  (root_side)
    );

    // Root choice, distance, hit point and squared length of its offset.
    rsi_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .in_root   (root_s),
        .in_side   (root_side),
        .center    (center),
        .out_valid (pt_valid),
        .out_ee    (pt_ee),
        .out_side  (pt_side)
    );

    // Length of the offset in Q17.16.
    rsi_isqrt #(
        .RAD_W  (rsi_pkg::EeW),
        .SIDE_W ($bits(rsi_pkg::norm_side_t))
    ) u_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pt_valid),
        .in_rad    (pt_ee),
        .in_side   (pt_side),
        .out_valid (len_valid),
        .out_root  (len_s),
        .out_side  (len_side)
    );

    // Normal components, rounded to nearest and clamped to Q2.14.
    rsi_ndiv u_ndiv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (len_valid),
        .in_len     (len_s),
        .in_side    (len_side),
        .out_valid  (div_valid),
        .out_normal (div_normal),
        .out_side   (div_side)
    );

    // A miss gives an all-zero result; a zero radius gives a zero normal.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_side.miss)
        begin
            hit_reg    <= 1'b0;
            dist_reg   <= '0;
            point_reg  <= '0;
            normal_reg <= '0;
        end
        else
        begin
            hit_reg    <= 1'b1;
            dist_reg   <= div_side.t16;
            point_reg  <= div_side.p;
            normal_reg <= (radius_reg == '0) ? '0 : div_normal;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign hit_x        = point_reg[0];
    assign hit_y        = point_reg[1];
    assign hit_z        = point_reg[2];
    assign normal_x     = normal_reg[0];
    assign normal_y     = normal_reg[1];
    assign normal_z     = normal_reg[2];

endmodule

>>> rtl/core/rsi_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband that travels along.
module rsi_isqrt #(
    parameter int RAD_W  = 100,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [RAD_W/2-1:0]    out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int ROOT_W = RAD_W / 2;

    logic [ROOT_W-1:0] vld_reg;
    logic [RAD_W-1:0]  rem_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg  [0:ROOT_W-1];
    logic [SIDE_W-1:0] side_reg  [0:ROOT_W-1];
    logic [RAD_W-1:0]  rem_cur   [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_cur  [0:ROOT_W-1];
    logic [RAD_W-1:0]  trial     [0:ROOT_W-1];
    logic [RAD_W-1:0]  rem_next  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_next [0:ROOT_W-1];

    // Stage g decides root bit ROOT_W-1-g; the remainder holds rad minus root squared.
    always_comb
    begin
        rem_cur[0]  = in_rad;
        root_cur[0] = '0;
        for (int g = 1; g < ROOT_W; g++)
        begin
            rem_cur[g]  = rem_reg[g-1];
            root_cur[g] = root_reg[g-1];
        end
        for (int g = 0; g < ROOT_W; g++)
        begin
            trial[g] = ({{(RAD_W - ROOT_W){1'b0}}, root_cur[g]} << (ROOT_W - g))
                     | ({{(RAD_W - 1){1'b0}}, 1'b1} << (2 * (ROOT_W - 1 - g)));
            if (rem_cur[g] >= trial[g])
            begin
                rem_next[g]  = rem_cur[g] - trial[g];
                root_next[g] = root_cur[g] | ({{(ROOT_W - 1){1'b0}}, 1'b1} << (ROOT_W - 1 - g));
            end
            else
            begin
                rem_next[g]  = rem_cur[g];
                root_next[g] = root_cur[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int g = 1; g < ROOT_W; g++)
        begin
            side_reg[g] <= side_reg[g-1];
        end
        for (int g = 0; g < ROOT_W; g++)
        begin
            rem_reg[g]  <= rem_next[g];
            root_reg[g] <= root_next[g];
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

>>> rtl/core/rsi_quad.sv
// Front pipeline: offset, dot products and the quarter discriminant of the ray quadratic.
module rsi_quad (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  rsi_pkg::ray_t                 in_ray,
    input  rsi_pkg::coord_t [2:0]         center,
    input  rsi_pkg::dist_t                radius,
    output logic                          out_valid,
    output logic [rsi_pkg::QW-1:0]        out_q,
    output rsi_pkg::root_side_t           out_side
);

    localparam int Stages = 7;
    localparam int DW     = rsi_pkg::DeltaW;
    localparam int PW     = rsi_pkg::DirW + DW;          // dir times offset
    localparam int SqW    = 2 * DW;                      // offset squared
    localparam int RrW    = 2 * rsi_pkg::DistW;
    localparam int KW     = SqW + 1;
    localparam int MagW   = PW;                          // |h| fits here
    localparam int LoW    = MagW / 2;
    localparam int HiW    = MagW - LoW;
    localparam int H2W    = 2 * MagW;

    logic [Stages-1:0]           vld_reg;
    rsi_pkg::ray_t               ray_reg  [0:Stages-1];
    logic signed [DW-1:0]        d_reg    [0:2];
    logic signed [PW-1:0]        hp_reg   [0:2];
    logic [SqW-1:0]              dsq_reg  [0:2];
    logic [RrW-1:0]              rr_reg;
    logic signed [rsi_pkg::HW-1:0] h_reg  [0:4];
    logic [SqW-1:0]              dd_reg;
    logic [RrW-1:0]              rr3_reg;
    logic [MagW-1:0]             hmag_reg;
    logic signed [KW-1:0]        k_reg    [0:2];
    logic [2*HiW-1:0]            pp_hh_reg;
    logic [HiW+LoW-1:0]          pp_hl_reg;
    logic [2*LoW-1:0]            pp_ll_reg;
    logic [H2W-1:0]              h2_reg;
    logic [rsi_pkg::QW-1:0]      q_reg;
    logic                        miss_reg;

    logic signed [rsi_pkg::HW-1:0] habs;
    logic signed [rsi_pkg::QW-1:0] qs;

    always_comb
    begin
        habs = h_reg[0][rsi_pkg::HW-1] ? -h_reg[0] : h_reg[0];
        qs   = $signed({{(rsi_pkg::QW - H2W){1'b0}}, h2_reg})
             + rsi_pkg::QW'($signed({k_reg[2], 28'd0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ray_reg[0] <= in_ray;
        for (int k = 1; k < Stages; k++)
        begin
            ray_reg[k] <= ray_reg[k-1];
        end
        // Stage 1: offset from the centre.
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i] <= DW'(in_ray.o[i]) - DW'(center[i]);
        end
        // Stage 2: products.
        for (int i = 0; i < 3; i++)
        begin
            hp_reg[i]  <= PW'(ray_reg[0].dv[i]) * PW'(d_reg[i]);
            dsq_reg[i] <= SqW'(d_reg[i]) * SqW'(d_reg[i]);
        end
        rr_reg <= RrW'(radius) * RrW'(radius);
        // Stage 3: sums.
        h_reg[0] <= rsi_pkg::HW'(hp_reg[0]) + rsi_pkg::HW'(hp_reg[1]) + rsi_pkg::HW'(hp_reg[2]);
        dd_reg   <= dsq_reg[0] + dsq_reg[1] + dsq_reg[2];
        rr3_reg  <= rr_reg;
        // Stage 4: magnitude of h and r*r - d.d.
        h_reg[1] <= h_reg[0];
        hmag_reg <= habs[MagW-1:0];
        k_reg[0] <= $signed({{(KW - RrW){1'b0}}, rr3_reg}) - $signed({1'b0, dd_reg});
        // Stage 5: partial products of h squared.
        h_reg[2]  <= h_reg[1];
        k_reg[1]  <= k_reg[0];
        pp_hh_reg <= (2*HiW)'(hmag_reg[MagW-1:LoW]) * (2*HiW)'(hmag_reg[MagW-1:LoW]);
        pp_hl_reg <= (HiW+LoW)'(hmag_reg[MagW-1:LoW]) * (HiW+LoW)'(hmag_reg[LoW-1:0]);
        pp_ll_reg <= (2*LoW)'(hmag_reg[LoW-1:0]) * (2*LoW)'(hmag_reg[LoW-1:0]);
        // Stage 6: h squared.
        h_reg[3] <= h_reg[2];
        k_reg[2] <= k_reg[1];
        h2_reg   <= {pp_hh_reg, {(2*LoW){1'b0}}}
                  + H2W'({pp_hl_reg, {(LoW+1){1'b0}}})
                  + H2W'(pp_ll_reg);
        // Stage 7: discriminant quarter; a negative one is a miss.
        h_reg[4] <= h_reg[3];
        miss_reg <= qs[rsi_pkg::QW-1];
        q_reg    <= qs[rsi_pkg::QW-1] ? '0 : qs;
    end

    assign out_valid     = vld_reg[Stages-1];
    assign out_q         = q_reg;
    assign out_side.miss = miss_reg;
    assign out_side.h    = h_reg[4];
    assign out_side.ray  = ray_reg[Stages-1];

endmodule

>>> rtl/core/rsi_point.sv
// Middle pipeline: root choice, rounded distance, hit point and the squared length of its offset.
module rsi_point (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [rsi_pkg::RootW-1:0]     in_root,
    input  rsi_pkg::root_side_t           in_side,
    input  rsi_pkg::coord_t [2:0]         center,
    output logic                          out_valid,
    output logic [rsi_pkg::EeW-1:0]       out_ee,
    output rsi_pkg::norm_side_t           out_side
);

    localparam int Stages = 7;
    localparam int TW     = rsi_pkg::RootW + 2;
    localparam int TrW    = TW - rsi_pkg::FracBits;
    localparam int MW     = rsi_pkg::CoordW + rsi_pkg::DirW;
    localparam int OffW   = MW - rsi_pkg::FracBits;
    localparam int SW     = OffW + 1;
    localparam int DW     = rsi_pkg::DeltaW;

    logic [Stages-1:0]                vld_reg;
    logic                             miss_reg  [0:Stages-1];
    rsi_pkg::ray_t                    ray_reg   [0:2];
    logic signed [TW-1:0]             t30_reg;
    rsi_pkg::dist_t                   t16_reg   [0:5];
    logic signed [MW-1:0]             prod_reg  [0:2];
    rsi_pkg::coord_t [2:0]            p_reg     [0:3];
    logic signed [DW-1:0]             e_reg     [0:2];
    logic [rsi_pkg::EeW-1:0]          esq_reg   [0:2];
    logic [2:0][DW-1:0]               emag_reg  [0:1];
    logic [2:0]                       esign_reg [0:1];
    logic [rsi_pkg::EeW-1:0]          ee_reg;

    logic signed [TW-1:0]  hs, sr, t1, t2;
    logic [TW-1:0]         tsum;
    logic [TrW-1:0]        t16raw;
    logic signed [MW-1:0]  rsum [0:2];
    logic signed [SW-1:0]  psum [0:2];
    rsi_pkg::coord_t [2:0] p_next;
    logic signed [DW-1:0]  eabs [0:2];

    always_comb
    begin
        hs     = TW'(in_side.h);
        sr     = $signed({2'b00, in_root});
        t1     = -hs - sr;
        t2     = sr - hs;
        tsum   = {1'b0, t30_reg[TW-2:0]} + TW'(rsi_pkg::RoundHalf);
        t16raw = tsum[TW-1:rsi_pkg::FracBits];
        for (int i = 0; i < 3; i++)
        begin
            rsum[i] = prod_reg[i] + MW'(rsi_pkg::RoundHalf);
            psum[i] = SW'(ray_reg[2].o[i]) + SW'($signed(rsum[i][MW-1:rsi_pkg::FracBits]));
            // Saturate the hit point to the signed coordinate range.
            if (psum[i][SW-1:rsi_pkg::CoordW-1] == '0 || psum[i][SW-1:rsi_pkg::CoordW-1] == '1)
            begin
                p_next[i] = psum[i][rsi_pkg::CoordW-1:0];
            end
            else if (psum[i][SW-1])
            begin
                p_next[i] = {1'b1, {(rsi_pkg::CoordW - 1){1'b0}}};
            end
            else
            begin
                p_next[i] = {1'b0, {(rsi_pkg::CoordW - 1){1'b1}}};
            end
            eabs[i] = e_reg[i][DW-1] ? -e_reg[i] : e_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 1: near root if strictly positive, else far root.
        miss_reg[0] <= in_side.miss | t2[TW-1];
        t30_reg     <= (t1 > 0) ? t1 : t2;
        ray_reg[0]  <= in_side.ray;
        for (int k = 1; k < Stages; k++)
        begin
            miss_reg[k] <= miss_reg[k-1];
        end
        ray_reg[1] <= ray_reg[0];
        ray_reg[2] <= ray_reg[1];
        // Stage 2: round to Q15.16 and saturate.
        t16_reg[0] <= (|t16raw[TrW-1:rsi_pkg::DistW]) ? '1 : t16raw[rsi_pkg::DistW-1:0];
        for (int k = 1; k < 6; k++)
        begin
            t16_reg[k] <= t16_reg[k-1];
        end
        // Stage 3: distance times direction.
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= MW'($signed({1'b0, t16_reg[0]})) * MW'(ray_reg[1].dv[i]);
        end
        // Stage 4: hit point.
        p_reg[0] <= p_next;
        for (int k = 1; k < 4; k++)
        begin
            p_reg[k] <= p_reg[k-1];
        end
        // Stage 5: offset of the hit point from the centre.
        for (int i = 0; i < 3; i++)
        begin
            e_reg[i] <= DW'(p_reg[0][i]) - DW'(center[i]);
        end
        // Stage 6: squares and magnitudes.
        for (int i = 0; i < 3; i++)
        begin
            esq_reg[i]      <= rsi_pkg::EeW'(e_reg[i]) * rsi_pkg::EeW'(e_reg[i]);
            emag_reg[0][i]  <= eabs[i];
            esign_reg[0][i] <= e_reg[i][DW-1];
        end
        // Stage 7: squared length.
        ee_reg       <= esq_reg[0] + esq_reg[1] + esq_reg[2];
        emag_reg[1]  <= emag_reg[0];
        esign_reg[1] <= esign_reg[0];
    end

    assign out_valid        = vld_reg[Stages-1];
    assign out_ee           = ee_reg;
    assign out_side.hs.miss = miss_reg[Stages-1];
    assign out_side.hs.t16  = t16_reg[5];
    assign out_side.hs.p    = p_reg[3];
    assign out_side.emag    = emag_reg[1];
    assign out_side.esign   = esign_reg[1];

endmodule

>>> rtl/core/rsi_ndiv.sv
// Pipelined restoring division of the hit offset by its length, three lanes, one quotient bit per stage.
module rsi_ndiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [rsi_pkg::LenW-1:0]      in_len,
    input  rsi_pkg::norm_side_t           in_side,
    output logic                          out_valid,
    output rsi_pkg::dir_t [2:0]           out_normal,
    output rsi_pkg::hit_side_t            out_side
);

    localparam int QB     = rsi_pkg::QuoW;
    localparam int NW     = rsi_pkg::NumW;
    localparam int LW     = rsi_pkg::LenW;
    localparam int Stages = QB + 2;

    logic [Stages-1:0]          vld_reg;
    logic [2:0][NW-1:0]         rem_reg   [0:QB];
    logic [2:0][QB-1:0]         quo_reg   [1:QB];
    logic [LW-1:0]              len_reg   [0:QB];
    logic [2:0]                 esign_reg [0:QB];
    logic                       nz_reg    [0:QB];
    rsi_pkg::hit_side_t         side_reg  [0:QB+1];
    rsi_pkg::dir_t [2:0]        norm_reg;

    logic [2:0][QB-1:0]         quo_cur   [1:QB];
    logic [2:0][NW-1:0]         rem_next  [1:QB];
    logic [2:0][QB-1:0]         quo_next  [1:QB];
    logic [NW-1:0]              trial     [1:QB];
    logic [QB-1:0]              mc        [0:2];
    rsi_pkg::dir_t [2:0]        norm_next;

    always_comb
    begin
        quo_cur[1] = '0;
        for (int g = 2; g <= QB; g++)
        begin
            quo_cur[g] = quo_reg[g-1];
        end
        for (int g = 1; g <= QB; g++)
        begin
            trial[g] = NW'(len_reg[g-1]) << (QB - g);
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[g-1][i] >= trial[g])
                begin
                    rem_next[g][i] = rem_reg[g-1][i] - trial[g];
                    quo_next[g][i] = quo_cur[g][i] | ({{(QB - 1){1'b0}}, 1'b1} << (QB - g));
                end
                else
                begin
                    rem_next[g][i] = rem_reg[g-1][i];
                    quo_next[g][i] = quo_cur[g][i];
                end
            end
        end
        // Clamp, apply the sign, and give a zero normal for a zero length.
        for (int i = 0; i < 3; i++)
        begin
            mc[i] = (quo_reg[QB][i] > rsi_pkg::NormMagMax) ? rsi_pkg::NormMagMax
                                                           : quo_reg[QB][i];
            if (!nz_reg[QB])
            begin
                norm_next[i] = '0;
            end
            else if (esign_reg[QB][i])
            begin
                norm_next[i] = '0 - mc[i];
            end
            else
            begin
                norm_next[i] = mc[i][QB-1] ? rsi_pkg::NormPosMax : mc[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // Numerator |e| * 2^14 plus half the length, for rounding to nearest.
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[0][i] <= NW'({in_side.emag[i], {rsi_pkg::FracBits{1'b0}}})
                           + NW'(in_len >> 1);
        end
        len_reg[0]   <= in_len;
        esign_reg[0] <= in_side.esign;
        nz_reg[0]    <= (in_len != '0);
        side_reg[0]  <= in_side.hs;
        for (int g = 1; g <= QB; g++)
        begin
            rem_reg[g]   <= rem_next[g];
            quo_reg[g]   <= quo_next[g];
            len_reg[g]   <= len_reg[g-1];
            esign_reg[g] <= esign_reg[g-1];
            nz_reg[g]    <= nz_reg[g-1];
            side_reg[g]  <= side_reg[g-1];
        end
        side_reg[QB+1] <= side_reg[QB];
        norm_reg       <= norm_next;
    end

    assign out_valid  = vld_reg[Stages-1];
    assign out_normal = norm_reg;
    assign out_side   = side_reg[QB+1];

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of the ray and sphere intersection unit, with its own fixed-point predictor.
`timescale 1ns / 1ps

module tb_top;

    // One result beat as the block presents it on its output ports.
    typedef struct {
        logic        hit;
        logic [30:0] hdist;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
    } isect_t;

    // A row of the directed table: either a sphere setting or a ray beat.
    // A ray row may carry a result typed in by hand; otherwise the predictor decides.
    typedef struct {
        bit       is_sphere;
        longint   a0;
        longint   a1;
        longint   a2;
        longint   a3;
        longint   v0;
        longint   v1;
        longint   v2;
        bit       typed;
        isect_t   want;
    } row_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    rsi_pkg::coord_t origin_x;
    rsi_pkg::coord_t origin_y;
    rsi_pkg::coord_t origin_z;
    rsi_pkg::dir_t   dir_x;
    rsi_pkg::dir_t   dir_y;
    rsi_pkg::dir_t   dir_z;
    logic            wr_en;
    logic [1:0]      wr_index;
    logic [31:0]     wr_data;
    logic            done;
    logic            hit;
    logic [30:0]     hit_distance;
    rsi_pkg::coord_t hit_x;
    rsi_pkg::coord_t hit_y;
    rsi_pkg::coord_t hit_z;
    rsi_pkg::dir_t   normal_x;
    rsi_pkg::dir_t   normal_y;
    rsi_pkg::dir_t   normal_z;

    // The typed result travels with its ray beat, so the monitor sees both at the same edge.
    logic        typed_flag;
    isect_t      typed_res;

    // Our copy of the sphere registers, updated from the write port as the block sees it.
    logic signed [31:0] sph_cx;
    logic signed [31:0] sph_cy;
    logic signed [31:0] sph_cz;
    logic [30:0]        sph_r;

    isect_t      awaited_hits[$];
    isect_t      mon_res;
    isect_t      mon_got;
    row_t        dir_rows[$];
    int          idle_pct;
    int          err_count;
    int          ray_count;
    int          hit_count;
    int          sphere_count;

    ray_sphere_intersect_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .origin_z     (origin_z),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .done         (done),
        .hit          (hit),
        .hit_distance (hit_distance),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .hit_z        (hit_z),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The run is ended here if the results never drain.
    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Integer square root, truncated, found one bit at a time from the top.
    function automatic logic [127:0] root128(logic [127:0] q);
        logic [127:0] s;
        logic [127:0] c;
        s = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = s | (128'd1 << b);
            if (c * c <= q)
                s = c;
        end
        return s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [127:0] mag128(longint v);
        return 128'(v < 0 ? -v : v);
    endfunction

    // Works out the result of one ray against the sphere currently held in the registers.
    function automatic isect_t trace_ray(longint ox, longint oy, longint oz,
                                         longint dx, longint dy, longint dz);
        longint       o[3];
        longint       dv[3];
        longint       c[3];
        longint       d[3];
        longint       p[3];
        longint       e[3];
        longint       h;
        longint       s;
        longint       t1;
        longint       t2;
        longint       t30;
        longint       t16;
        longint       len;
        longint       m;
        longint       n;
        logic [127:0] dd;
        logic [127:0] ee;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] mg;
        isect_t       rs;
        rs = '{default: '0};
        o[0] = ox; o[1] = oy; o[2] = oz;
        dv[0] = dx; dv[1] = dy; dv[2] = dz;
        c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
        h = 0;
        dd = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = o[i] - c[i];
            h += dv[i] * d[i];
            mg = mag128(d[i]);
            dd += mg * mg;
        end
        // Compare the quarter discriminant in Q.60 before taking its root.
        mg = mag128(h);
        a = mg * mg + ((128'(sph_r) * 128'(sph_r)) << 28);
        b = dd << 28;
        if (b > a)
            return rs;
        s = longint'(root128(a - b));
        t1 = -h - s;
        t2 = -h + s;
        if (t2 < 0)
            return rs;
        t30 = (t1 > 0) ? t1 : t2;
        t16 = (t30 + 8192) >>> 14;
        if (t16 > 64'sd2147483647)
            t16 = 64'sd2147483647;
        ee = '0;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = clip32(o[i] + ((t16 * dv[i] + 8192) >>> 14));
            e[i] = p[i] - c[i];
            mg = mag128(e[i]);
            ee += mg * mg;
        end
        len = longint'(root128(ee));
        rs.hit = 1'b1;
        rs.hdist = t16[30:0];
        rs.px = p[0][31:0];
        rs.py = p[1][31:0];
        rs.pz = p[2][31:0];
        for (int i = 0; i < 3; i++)
        begin
            n = 0;
            if (sph_r != 0 && len != 0)
            begin
                m = (((e[i] < 0) ? -e[i] : e[i]) * 16384 + len / 2) / len;
                if (m > 32768)
                    m = 32768;
                n = (e[i] < 0) ? -m : m;
                if (n > 32767)
                    n = 32767;
            end
            if (i == 0)
                rs.nx = n[15:0];
            else if (i == 1)
                rs.ny = n[15:0];
            else
                rs.nz = n[15:0];
        end
        return rs;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Monitor: shadows register writes, predicts each accepted ray and checks each done beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_en)
            begin
                case (rsi_pkg::cfg_reg_t'(wr_index))
                    rsi_pkg::REG_CENTER_X: sph_cx <= wr_data;
                    rsi_pkg::REG_CENTER_Y: sph_cy <= wr_data;
                    rsi_pkg::REG_CENTER_Z: sph_cz <= wr_data;
                    rsi_pkg::REG_RADIUS:   sph_r  <= wr_data[30:0];
                    default:               sph_r  <= sph_r;
                endcase
            end
            if (start && !busy)
            begin
                if (typed_flag)
                    mon_res = typed_res;
                else
                    mon_res = trace_ray(origin_x, origin_y, origin_z, dir_x, dir_y, dir_z);
                awaited_hits.push_back(mon_res);
                ray_count++;
            end
            if (done)
            begin
                if (awaited_hits.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual hit %0b dist %0d",
                             $time, hit, hit_distance);
                    err_count++;
                end
                else
                begin
                    mon_res = awaited_hits.pop_front();
                    mon_got = '{hit, hit_distance, hit_x, hit_y, hit_z,
                                normal_x, normal_y, normal_z};
                    check_field("hit", mon_res.hit, mon_got.hit);
                    check_field("hit_distance", mon_res.hdist, mon_got.hdist);
                    check_field("hit_x", $signed(mon_res.px), $signed(mon_got.px));
                    check_field("hit_y", $signed(mon_res.py), $signed(mon_got.py));
                    check_field("hit_z", $signed(mon_res.pz), $signed(mon_got.pz));
                    check_field("normal_x", $signed(mon_res.nx), $signed(mon_got.nx));
                    check_field("normal_y", $signed(mon_res.ny), $signed(mon_got.ny));
                    check_field("normal_z", $signed(mon_res.nz), $signed(mon_got.nz));
                    if (mon_got.hit)
                        hit_count++;
                end
            end
        end
    end

    // Sends one ray beat, idling beforehand as the current idle share says.
    task automatic send_ray(longint ox, longint oy, longint oz,
                            longint dx, longint dy, longint dz,
                            bit typed, isect_t want);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        origin_x   <= ox[31:0];
        origin_y   <= oy[31:0];
        origin_z   <= oz[31:0];
        dir_x      <= dx[15:0];
        dir_y      <= dy[15:0];
        dir_z      <= dz[15:0];
        typed_flag <= typed;
        typed_res  <= want;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Changes the sphere once every outstanding result has come back.
    task automatic set_sphere(longint cx, longint cy, longint cz, longint r);
        start <= 1'b0;
        @(posedge clk);
        while (awaited_hits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= rsi_pkg::REG_CENTER_X;
        wr_data  <= cx[31:0];
        @(posedge clk);
        wr_index <= rsi_pkg::REG_CENTER_Y;
        wr_data  <= cy[31:0];
        @(posedge clk);
        wr_index <= rsi_pkg::REG_CENTER_Z;
        wr_data  <= cz[31:0];
        @(posedge clk);
        wr_index <= rsi_pkg::REG_RADIUS;
        wr_data  <= {1'b0, r[30:0]};
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        sphere_count++;
    endtask

    task automatic add_row(bit is_sphere, longint a0, longint a1, longint a2, longint a3,
                           longint v0, longint v1, longint v2, bit typed, isect_t want);
        row_t rw;
        rw = '{is_sphere, a0, a1, a2, a3, v0, v1, v2, typed, want};
        dir_rows.push_back(rw);
    endtask

    function automatic real rnd_span(real span);
        return span * real'(int'($urandom_range(0, 200000)) - 100000) / 100000.0;
    endfunction

    // A phase of random rays: most are aimed near the sphere, the rest are raw noise.
    task automatic random_rays(int count);
        longint o[3];
        longint dq[3];
        longint c[3];
        real    v[3];
        real    rad_u;
        real    len;
        isect_t none;
        none = '{default: '0};
        for (int k = 0; k < count; k++)
        begin
            c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
            if ($urandom_range(0, 99) < 80)
            begin
                rad_u = real'(sph_r) / 65536.0;
                for (int i = 0; i < 3; i++)
                    o[i] = clip32(c[i] + longint'(rnd_span(3.0 * rad_u + 4.0) * 65536.0));
                len = 0.0;
                for (int i = 0; i < 3; i++)
                begin
                    v[i] = real'(c[i] - o[i]) / 65536.0 + rnd_span(1.5 * rad_u + 1.0);
                    len += v[i] * v[i];
                end
                len = $sqrt(len);
                if (len < 1.0e-9)
                begin
                    v[0] = 1.0; v[1] = 0.0; v[2] = 0.0; len = 1.0;
                end
                for (int i = 0; i < 3; i++)
                    dq[i] = $rtoi(v[i] / len * 16384.0);
                // Now and then the direction is left far from unit length.
                if ($urandom_range(0, 19) == 0)
                    for (int i = 0; i < 3; i++)
                        dq[i] = $signed(16'($urandom));
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    o[i] = $signed(32'($urandom));
                    dq[i] = $signed(16'($urandom));
                end
            end
            send_ray(o[0], o[1], o[2], dq[0], dq[1], dq[2], 1'b0, none);
        end
    endtask

    initial
    begin
        isect_t none;
        isect_t at_centre;
        none = '{default: '0};
        at_centre = '{default: '0};
        at_centre.hit   = 1'b1;
        at_centre.hdist = 31'd196608;
        at_centre.px    = 32'd196608;
        err_count    = 0;
        ray_count    = 0;
        hit_count    = 0;
        sphere_count = 0;
        idle_pct     = 25;
        sph_cx = '0; sph_cy = '0; sph_cz = '0; sph_r = '0;
        rst_n      = 1'b0;
        start      = 1'b0;
        origin_x   = '0;
        origin_y   = '0;
        origin_z   = '0;
        dir_x      = '0;
        dir_y      = '0;
        dir_z      = '0;
        wr_en      = 1'b0;
        wr_index   = rsi_pkg::REG_CENTER_X;
        wr_data    = '0;
        typed_flag = 1'b0;
        typed_res  = none;

        // Reset values: a point sphere at the origin. A ray from it hits at zero distance.
        add_row(0, 0, 0, 0, 0, 16384, 0, 0, 1, '{1'b1, '0, '0, '0, '0, '0, '0, '0});
        add_row(0, 65536, 0, 0, 0, 16384, 0, 0, 1, none);
        add_row(0, 2147483647, 2147483647, 2147483647, 0, 32767, 32767, 32767, 0, none);
        add_row(0, -2147483648, -2147483648, -2147483648, 0, -32768, -32768, -32768, 0, none);
        // Unit sphere at the origin: a plain hit, an origin inside, a tangent, a root at the
        // origin itself, a sphere behind the ray and a direction far from unit length.
        add_row(1, 0, 0, 0, 65536, 0, 0, 0, 0, none);
        add_row(0, -327680, 0, 0, 0, 16384, 0, 0, 0, none);
        add_row(0, 0, 0, 0, 0, 0, 16384, 0, 0, none);
        add_row(0, -327680, 65536, 0, 0, 16384, 0, 0, 0, none);
        add_row(0, -65536, 0, 0, 0, 16384, 0, 0, 0, none);
        add_row(0, 327680, 0, 0, 0, 16384, 0, 0, 1, none);
        add_row(0, -327680, 0, 0, 0, 32767, -32768, 0, 0, none);
        add_row(0, -2147483648, 2147483647, -2147483648, 0, -32768, 32767, -32768, 0, none);
        // Extreme centre and the largest radius: distance and hit point saturate.
        add_row(1, 2147483647, -2147483648, 2147483647, 2147483647, 0, 0, 0, 0, none);
        add_row(0, -2147483648, 2147483647, -2147483648, 0, 16384, 0, 0, 0, none);
        add_row(0, 2147483647, -2147483648, 2147483647, 0, 0, 0, 16384, 0, none);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, 0, 0, -32768, 32767, -32768, 0, none);
        // Zero radius: the ray meets the centre itself and the normal is zero.
        add_row(1, 196608, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, 0, 0, 16384, 0, 0, 1, at_centre);
        add_row(0, 0, 65536, 0, 0, 16384, 0, 0, 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_sphere)
                set_sphere(dir_rows[i].a0, dir_rows[i].a1, dir_rows[i].a2, dir_rows[i].a3);
            else
                send_ray(dir_rows[i].a0, dir_rows[i].a1, dir_rows[i].a2,
                         dir_rows[i].v0, dir_rows[i].v1, dir_rows[i].v2,
                         dir_rows[i].typed, dir_rows[i].want);
        end

        // Three phases of idling; within each, four spheres from ordinary to extreme.
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 25 : ((ph == 1) ? 87 : 0);
            for (int sc = 0; sc < 4; sc++)
            begin
                case (sc)
                    0: set_sphere(longint'($rtoi(rnd_span(1000.0) * 65536.0)),
                                  longint'($rtoi(rnd_span(1000.0) * 65536.0)),
                                  longint'($rtoi(rnd_span(1000.0) * 65536.0)),
                                  longint'($urandom_range(65536, 200 * 65536)));
                    1: begin
                        if (ph == 0)
                            set_sphere(2147483647, -2147483648, 2147483647, 2147483647);
                        else if (ph == 1)
                            set_sphere(-2147483648, 2147483647, -2147483648, 2147483647);
                        else
                            set_sphere(0, 0, 0, 2147483647);
                    end
                    2: set_sphere(longint'($rtoi(rnd_span(50.0) * 65536.0)),
                                  longint'($rtoi(rnd_span(50.0) * 65536.0)),
                                  longint'($rtoi(rnd_span(50.0) * 65536.0)), 0);
                    default: set_sphere($signed(32'($urandom)), $signed(32'($urandom)),
                                        $signed(32'($urandom)), longint'($urandom) & 'h7FFFFFFF);
                endcase
                random_rays(163);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (awaited_hits.size() != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);

        $display("Covered %0d rays over %0d sphere settings, %0d of them hits.",
                 ray_count, sphere_count, hit_count);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
